[hw/rtl/deq_pkg.sv]
package deq_pkg;

  localparam int unsigned DEQ_DEPTH  = 64;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CNT_OUT_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_END   = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_END    = 3'd3,
    OP_ERASE      = 3'd4,
    OP_COUNT      = 3'd5
  } deq_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_FULL      = 2'd2
  } deq_status_e;

  typedef struct packed {
    deq_status_e                status;
    logic signed [DATA_W-1:0]   popped_value;
    logic [CNT_OUT_W-1:0]       match_count;
    logic [CNT_OUT_W-1:0]       occupancy;
    logic signed [DATA_W-1:0]   front_value;
    logic signed [DATA_W-1:0]   last_value;
    logic                       is_empty;
  } deq_result_t;

endpackage

[hw/rtl/deque_with_value_erase.sv]
// Channel  Direction  Handshake                 Payload
// in       sink       in_valid_i / in_stall_o   operation_i, value_i
// out      source     out_valid_o / out_stall_i status_o, popped_value_o, match_count_o,
//                                               occupancy_o, front_value_o, end_value_o,
//                                               is_empty_o
//
// One request at a time through a ring memory with one write port and a registered read.
// Push or ignored code: execute, read front and end; pop: capture the entry first.
// Erase and count walk one entry per cycle. Front and end reads are skipped
// when the queue is or ends empty; on an empty queue a no-op request reads no memory.
// Reset clears head, occupancy and all state; the memory needs no clearing pass.
// A stalled result holds in the output register while the next request runs.
module deque_with_value_erase #(
  parameter int unsigned DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [deq_pkg::OP_W-1:0]             operation_i,
  input  logic signed [deq_pkg::DATA_W-1:0]    value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [deq_pkg::STATUS_W-1:0]         status_o,
  output logic signed [deq_pkg::DATA_W-1:0]    popped_value_o,
  output logic [deq_pkg::CNT_OUT_W-1:0]        match_count_o,
  output logic [deq_pkg::CNT_OUT_W-1:0]        occupancy_o,
  output logic signed [deq_pkg::DATA_W-1:0]    front_value_o,
  output logic signed [deq_pkg::DATA_W-1:0]    end_value_o,
  output logic                                 is_empty_o
);
  import deq_pkg::*;

  logic        res_valid;
  logic        res_take;
  deq_result_t res;
  logic        out_valid_q;
  deq_result_t out_q;

  deq_seq #(.DEPTH(DEPTH)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .value_i     (value_i),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  // Load when the output register is empty or being drained this cycle.
  assign res_take = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res_take) begin
      out_valid_q <= res_valid;
      if (res_valid) begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign popped_value_o = out_q.popped_value;
  assign match_count_o  = out_q.match_count;
  assign occupancy_o    = out_q.occupancy;
  assign front_value_o  = out_q.front_value;
  assign end_value_o    = out_q.last_value;
  assign is_empty_o     = out_q.is_empty;

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (is_empty_o == (occupancy_o == '0 && DEPTH < 128)) || DEPTH >= 128)
    else $error("empty flag disagrees with occupancy");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && is_empty_o) |-> (front_value_o == '0 && end_value_o == '0))
    else $error("empty result shows stale entries");

  a_no_lost_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result dropped");

endmodule

[hw/rtl/deq_ram.sv]
module deq_ram #(
  parameter int unsigned DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [$clog2(DEPTH)-1:0]        waddr_i,
  input  logic [deq_pkg::DATA_W-1:0]      wdata_i,
  input  logic [$clog2(DEPTH)-1:0]        raddr_i,
  output logic [deq_pkg::DATA_W-1:0]      rdata_o
);
  import deq_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/deq_seq.sv]
module deq_seq #(
  parameter int unsigned DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [deq_pkg::OP_W-1:0]          operation_i,
  input  logic signed [deq_pkg::DATA_W-1:0] value_i,
  output logic                              res_valid_o,
  input  logic                              res_take_i,
  output deq_pkg::deq_result_t              res_o
);
  import deq_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = IW + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_CAP,
    S_WALK,
    S_FRONT_RD,
    S_END_RD,
    S_END_CAP,
    S_EMIT
  } state_e;

  state_e             state_q, state_d;
  logic [OP_W-1:0]    op_q, op_d;
  logic [DATA_W-1:0]  val_q, val_d;
  logic [IW-1:0]      head_q, head_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      rd_idx_q, rd_idx_d;
  logic [CW-1:0]      kept_q, kept_d;
  logic [CW-1:0]      match_q, match_d;
  logic               pend_q, pend_d;
  deq_status_e        status_q, status_d;
  logic [DATA_W-1:0]  popped_q, popped_d;
  logic [DATA_W-1:0]  front_q, front_d;
  logic [DATA_W-1:0]  last_q, last_d;

  logic               we;
  logic [IW-1:0]      waddr;
  logic [DATA_W-1:0]  wdata;
  logic [IW-1:0]      raddr;
  logic [DATA_W-1:0]  rdata;
  logic               full;
  logic               empty;

  // Ring slot of an offset from the head; the sum stays below twice DEPTH.
  function automatic logic [IW-1:0] slot(input logic [IW-1:0] h, input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[IW-1:0];
  endfunction

  deq_ram #(.DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    val_d    = val_q;
    head_d   = head_q;
    count_d  = count_q;
    rd_idx_d = rd_idx_q;
    kept_d   = kept_q;
    match_d  = match_q;
    pend_d   = pend_q;
    status_d = status_q;
    popped_d = popped_q;
    front_d  = front_q;
    last_d   = last_q;
    we       = 1'b0;
    waddr    = head_q;
    wdata    = val_q;
    raddr    = head_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = operation_i;
          val_d    = value_i;
          rd_idx_d = '0;
          kept_d   = '0;
          match_d  = '0;
          pend_d   = 1'b0;
          status_d = ST_OK;
          popped_d = '0;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        case (op_q)
          OP_PUSH_FRONT: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              head_d  = (head_q == '0) ? IW'(DEPTH - 1) : head_q - 1'b1;
              we      = 1'b1;
              waddr   = head_d;
              count_d = count_q + 1'b1;
            end
            state_d = S_FRONT_RD;
          end
          OP_PUSH_END: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              we      = 1'b1;
              waddr   = slot(head_q, count_q);
              count_d = count_q + 1'b1;
            end
            state_d = S_FRONT_RD;
          end
          OP_POP_FRONT, OP_POP_END: begin
            if (empty) begin
              status_d = ST_UNDERFLOW;
              state_d  = S_EMIT;
            end else begin
              raddr   = (op_q == OP_POP_FRONT) ? head_q : slot(head_q, count_q - 1'b1);
              state_d = S_POP_CAP;
            end
          end
          OP_ERASE: begin
            if (empty) begin
              status_d = ST_UNDERFLOW;
              state_d  = S_EMIT;
            end else begin
              state_d = S_WALK;
            end
          end
          OP_COUNT: begin
            state_d = S_WALK;
          end
          default: begin
            state_d = empty ? S_EMIT : S_FRONT_RD;
          end
        endcase
      end
      S_POP_CAP: begin
        popped_d = rdata;
        if (op_q == OP_POP_FRONT) begin
          head_d = slot(head_q, CW'(1));
        end
        count_d = count_q - 1'b1;
        state_d = (count_q == CW'(1)) ? S_EMIT : S_FRONT_RD;
      end
      S_WALK: begin
        // Compare the entry read last cycle; compact survivors toward the head.
        if (pend_q) begin
          if (rdata == val_q) begin
            match_d = match_q + 1'b1;
          end else if (op_q == OP_ERASE) begin
            we     = 1'b1;
            waddr  = slot(head_q, kept_q);
            wdata  = rdata;
            kept_d = kept_q + 1'b1;
          end
        end
        if (rd_idx_q != count_q) begin
          raddr    = slot(head_q, rd_idx_q);
          rd_idx_d = rd_idx_q + 1'b1;
          pend_d   = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (op_q == OP_ERASE) begin
            count_d = kept_d;
          end
          state_d = (count_d == '0) ? S_EMIT : S_FRONT_RD;
        end
      end
      S_FRONT_RD: begin
        raddr   = head_q;
        state_d = S_END_RD;
      end
      S_END_RD: begin
        front_d = rdata;
        raddr   = slot(head_q, count_q - 1'b1);
        state_d = S_END_CAP;
      end
      S_END_CAP: begin
        last_d  = rdata;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= '0;
      val_q    <= '0;
      head_q   <= '0;
      count_q  <= '0;
      rd_idx_q <= '0;
      kept_q   <= '0;
      match_q  <= '0;
      pend_q   <= 1'b0;
      status_q <= ST_OK;
      popped_q <= '0;
      front_q  <= '0;
      last_q   <= '0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      val_q    <= val_d;
      head_q   <= head_d;
      count_q  <= count_d;
      rd_idx_q <= rd_idx_d;
      kept_q   <= kept_d;
      match_q  <= match_d;
      pend_q   <= pend_d;
      status_q <= status_d;
      popped_q <= popped_d;
      front_q  <= front_d;
      last_q   <= last_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_EMIT);

  always_comb begin
    res_o.status       = status_q;
    res_o.popped_value = popped_q;
    res_o.match_count  = CNT_OUT_W'(match_q);
    res_o.occupancy    = CNT_OUT_W'(count_q);
    res_o.front_value  = empty ? '0 : front_q;
    res_o.last_value   = empty ? '0 : last_q;
    res_o.is_empty     = empty;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_erase_books: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && op_q == OP_ERASE) |->
      ((CW+1)'(kept_q) + (CW+1)'(match_q) + (CW+1)'(pend_q) == (CW+1)'(rd_idx_q)))
    else $error("erase walk lost track of entries");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == S_EXEC || state_q == S_WALK))
    else $error("memory write outside push or erase");

  a_walk_no_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && state_d != S_WALK) |=> count_q <= $past(count_q))
    else $error("walk grew the queue");

endmodule
